### hdl/ufd_pkg.sv
// types and constants shared by the form decoder modules
package ufd_pkg;

    // result item kinds
    typedef enum logic [1:0] {
        KIND_NAME  = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_END   = 2'd2
    } kind_t;

    // configuration register indexes
    localparam logic [1:0] REG_MAX_NAME_CHARS  = 2'd0;
    localparam logic [1:0] REG_MAX_VALUE_CHARS = 2'd1;
    localparam logic [1:0] REG_MAX_FIELDS      = 2'd2;

    // reset values of the configuration registers
    localparam logic [7:0] MAX_NAME_RESET  = 8'd254;
    localparam logic [7:0] MAX_VALUE_RESET = 8'd255;
    localparam logic [6:0] MAX_FIELDS_RESET = 7'd63;

    // special characters of the body syntax
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // most results one body byte can cause
    localparam int MAX_RESULTS = 4;

    // configuration seen by the decoding front end
    typedef struct packed {
        logic [7:0] max_name_chars;
        logic [7:0] max_value_chars;
        logic [6:0] max_fields;
    } cfg_t;

    // one result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data_byte;
        logic [6:0] field_index;
        logic       accepted;
        logic       last;
    } result_t;

    // all results caused by one body byte
    typedef struct packed {
        logic [2:0]                      cnt;
        result_t [MAX_RESULTS-1:0]       res;
    } batch_t;

endpackage

### hdl/ufd_front.sv
// decoding front end: parses body bytes and builds result batches
module ufd_front
    import ufd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_body,
    input  logic       q_full,
    output logic       push,
    output batch_t     push_batch
);

    // working set while one byte is decoded
    typedef struct packed {
        logic [2:0] n;
        logic [7:0] vlen;
        result_t [MAX_RESULTS-1:0] res;
    } work_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    logic       in_value_phase_reg, in_value_phase_next;
    logic       field_open_reg, field_open_next;
    logic [1:0] held_count_reg, held_count_next;
    logic [7:0] held_digit_reg, held_digit_next;
    logic [6:0] field_count_reg, field_count_next;
    logic [7:0] name_length_reg, name_length_next;
    logic [7:0] value_length_reg, value_length_next;
    work_t      work;

    function automatic hex_t hex_value(input logic [7:0] c);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.val = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.val = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.val = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic work_t append(input work_t w, input kind_t k, input logic [7:0] b,
                                     input logic [6:0] idx, input logic acc);
        work_t r;
        r = w;
        r.res[w.n[1:0]].kind        = k;
        r.res[w.n[1:0]].data_byte   = b;
        r.res[w.n[1:0]].field_index = idx;
        r.res[w.n[1:0]].accepted    = acc;
        r.res[w.n[1:0]].last        = 1'b0;
        r.n = w.n + 3'd1;
        return r;
    endfunction

    // keep a value byte while under the limit, emit it for stored fields
    function automatic work_t put_value(input work_t w, input logic [7:0] b,
                                        input logic acc, input logic [7:0] maxv,
                                        input logic [6:0] idx);
        work_t r;
        r = w;
        if (w.vlen < maxv) begin
            r.vlen = w.vlen + 8'd1;
            if (acc) begin
                r = append(r, KIND_VALUE, b, idx, 1'b1);
            end
        end
        return r;
    endfunction

    assign s_ready = !q_full;

    // decode one byte against the current field state
    always_comb begin
        logic       acc;
        logic       end_field;
        logic       handled;
        hex_t       hc_new;
        hex_t       hc_old;
        logic [7:0] decoded;
        logic [7:0] c;

        c                   = s_in_byte;
        in_value_phase_next = in_value_phase_reg;
        field_open_next     = field_open_reg;
        held_count_next     = held_count_reg;
        held_digit_next     = held_digit_reg;
        field_count_next    = field_count_reg;
        name_length_next    = name_length_reg;
        end_field           = 1'b0;
        handled             = 1'b0;
        work                = '0;
        work.vlen           = value_length_reg;

        // any byte while no field is open starts one
        if (!field_open_reg) begin
            field_open_next     = 1'b1;
            in_value_phase_next = 1'b0;
            name_length_next    = 8'd0;
            work.vlen           = 8'd0;
            held_count_next     = 2'd0;
            held_digit_next     = 8'd0;
        end
        acc = field_count_reg < cfg.max_fields;

        hc_new  = hex_value(c);
        hc_old  = hex_value(held_digit_next);
        decoded = {hc_old.val, hc_new.val};

        if (!in_value_phase_next) begin
            // name phase: literal bytes up to the equals sign
            if (c == CHAR_EQUALS) begin
                in_value_phase_next = 1'b1;
            end else if (name_length_next < cfg.max_name_chars) begin
                name_length_next = name_length_next + 8'd1;
                if (acc) begin
                    work = append(work, KIND_NAME, c, field_count_reg, 1'b1);
                end
            end
        end else if (c == CHAR_AMP) begin
            end_field = 1'b1;
        end else begin
            // value phase: escape handling
            if (held_count_next == 2'd1) begin
                if (hc_new.ok) begin
                    held_digit_next = c;
                    held_count_next = 2'd2;
                    handled         = 1'b1;
                end else begin
                    work = put_value(work, CHAR_PERCENT, acc, cfg.max_value_chars,
                                     field_count_reg);
                    held_count_next = 2'd0;
                end
            end else if (held_count_next == 2'd2) begin
                if (hc_new.ok) begin
                    held_count_next = 2'd0;
                    work = put_value(work, decoded, acc, cfg.max_value_chars,
                                     field_count_reg);
                    handled = 1'b1;
                end else begin
                    work = put_value(work, CHAR_PERCENT, acc, cfg.max_value_chars,
                                     field_count_reg);
                    work = put_value(work, held_digit_next, acc, cfg.max_value_chars,
                                     field_count_reg);
                    held_count_next = 2'd0;
                end
            end
            if (!handled && work.vlen < cfg.max_value_chars) begin
                if (c == CHAR_PLUS) begin
                    work = put_value(work, CHAR_SPACE, acc, cfg.max_value_chars,
                                     field_count_reg);
                end else if (c == CHAR_PERCENT) begin
                    held_count_next = 2'd1;
                end else begin
                    work = put_value(work, c, acc, cfg.max_value_chars, field_count_reg);
                end
            end
        end

        if (s_end_of_body) begin
            end_field = 1'b1;
        end

        // close the field: flush held escape bytes and emit the end item
        if (end_field) begin
            if (held_count_next != 2'd0) begin
                work = put_value(work, CHAR_PERCENT, acc, cfg.max_value_chars,
                                 field_count_reg);
            end
            if (held_count_next == 2'd2) begin
                work = put_value(work, held_digit_next, acc, cfg.max_value_chars,
                                 field_count_reg);
            end
            work = append(work, KIND_END, 8'd0,
                          acc ? field_count_reg : cfg.max_fields, acc);
            if (acc) begin
                field_count_next = field_count_reg + 7'd1;
            end
            field_open_next     = 1'b0;
            in_value_phase_next = 1'b0;
            held_count_next     = 2'd0;
            held_digit_next     = 8'd0;
            name_length_next    = 8'd0;
            work.vlen           = 8'd0;
        end
        if (s_end_of_body) begin
            field_count_next = 7'd0;
        end

        if (work.n != 3'd0) begin
            work.res[2'(work.n - 3'd1)].last = 1'b1;
        end
        value_length_next = work.vlen;
    end

    // batch toward the queue
    assign push           = s_valid && s_ready && (work.n != 3'd0);
    assign push_batch.cnt = work.n;
    assign push_batch.res = work.res;

    // field state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_value_phase_reg <= 1'b0;
            field_open_reg     <= 1'b0;
            held_count_reg     <= 2'd0;
            held_digit_reg     <= 8'd0;
            field_count_reg    <= 7'd0;
            name_length_reg    <= 8'd0;
            value_length_reg   <= 8'd0;
        end else if (s_valid && s_ready) begin
            in_value_phase_reg <= in_value_phase_next;
            field_open_reg     <= field_open_next;
            held_count_reg     <= held_count_next;
            held_digit_reg     <= held_digit_next;
            field_count_reg    <= field_count_next;
            name_length_reg    <= name_length_next;
            value_length_reg   <= value_length_next;
        end
    end

endmodule

### hdl/ufd_queue.sv
// queue of result batches between the front end and the output side
module ufd_queue
    import ufd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  batch_t push_batch,
    output logic   full,
    input  logic   pop,
    output logic   head_valid,
    output batch_t head_batch
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    batch_t             entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_batch = entries_reg[rd_ptr_reg];

    // pointer and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // batch storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_batch;
        end
    end

endmodule

### hdl/ufd_back.sv
// output side: sends the results of each batch one transfer at a time
module ufd_back
    import ufd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  batch_t     head_batch,
    output logic       pop,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [6:0] m_field_index,
    output logic       m_accepted,
    output logic       m_last
);

    logic       out_valid_reg, out_valid_next;
    result_t    out_data_reg;
    logic [1:0] sub_reg, sub_next;
    logic       load;

    // the output register takes a new result whenever it is empty or being taken
    assign load = head_valid && (!out_valid_reg || m_ready);
    assign pop  = load && ({1'b0, sub_reg} == head_batch.cnt - 3'd1);

    always_comb begin
        sub_next       = sub_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            sub_next       = pop ? 2'd0 : sub_reg + 2'd1;
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sub_reg       <= 2'd0;
        end else begin
            out_valid_reg <= out_valid_next;
            sub_reg       <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_data_reg <= head_batch.res[sub_reg];
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_kind        = out_data_reg.kind;
    assign m_data_byte   = out_data_reg.data_byte;
    assign m_field_index = out_data_reg.field_index;
    assign m_accepted    = out_data_reg.accepted;
    assign m_last        = out_data_reg.last;

endmodule

### hdl/urlencoded_form_decoder.sv
// URL-encoded form body decoder, top level
// Takes one body byte per cycle and decodes it in the same cycle into up to four
// results, which wait as one batch in a small queue (QUEUE_DEPTH batches) and
// leave through a registered output at one result per cycle while m_ready is
// high. A byte is taken whenever the queue has room, so input runs at one byte
// per cycle while the output keeps up; a byte that causes several results holds
// the output for each, so the total number of results sets the sustained rate.
// Configuration registers: index 0 max_name_chars, 1 max_value_chars,
// 2 max_fields; write them only while the block is idle.
module urlencoded_form_decoder
    import ufd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_index,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_end_of_body,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_data_byte,
    output logic [6:0] m_field_index,
    output logic       m_accepted,
    output logic       m_last
);

    cfg_t   cfg_reg;
    logic   q_full;
    logic   push;
    batch_t push_batch;
    logic   pop;
    logic   head_valid;
    batch_t head_batch;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_name_chars  <= MAX_NAME_RESET;
            cfg_reg.max_value_chars <= MAX_VALUE_RESET;
            cfg_reg.max_fields      <= MAX_FIELDS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_MAX_NAME_CHARS:  cfg_reg.max_name_chars  <= cfg_wr_data;
                REG_MAX_VALUE_CHARS: cfg_reg.max_value_chars <= cfg_wr_data;
                REG_MAX_FIELDS:      cfg_reg.max_fields      <= cfg_wr_data[6:0];
                default: begin
                end
            endcase
        end
    end

    ufd_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_body (s_end_of_body),
        .q_full        (q_full),
        .push          (push),
        .push_batch    (push_batch)
    );

    ufd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_batch (push_batch),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_batch (head_batch)
    );

    ufd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head_batch    (head_batch),
        .pop           (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_data_byte   (m_data_byte),
        .m_field_index (m_field_index),
        .m_accepted    (m_accepted),
        .m_last        (m_last)
    );

endmodule
